### rtl/alm_pkg.sv
// ----------------------------------------------------------------------------
// alm_pkg
// shared widths, constants and controller/datapath interface types for the
// audio level meter
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package alm_pkg;

   // buffer size limit and derived widths
   localparam int MAX_PAIRS  = 1024;
   localparam int CNT_W      = $clog2(MAX_PAIRS + 1);
   localparam int SUM_W      = $clog2(MAX_PAIRS) + 32;
   localparam int NUM_W      = SUM_W + 1;
   localparam int QUO_W      = 33;
   localparam int RAD_W      = QUO_W + 1;
   localparam int ROOT_STEPS = RAD_W / 2;
   localparam int ROOT_W     = ROOT_STEPS;
   localparam int RREM_W     = ROOT_W + 3;
   localparam int STEP_W     = $clog2(NUM_W);
   localparam int CSR_IDX_W  = 2;

   // fixed-point constants
   localparam logic [15:0] SMOOTH_OLD  = 16'd60948;
   localparam logic [15:0] SMOOTH_NEW  = 16'd4588;
   localparam logic [31:0] SMOOTH_RND  = 32'd32768;
   localparam logic [15:0] PEAK_DECAY  = 16'd66;
   localparam logic [15:0] ALPHA_KNEE  = 16'd3276;
   localparam logic [15:0] LEVEL_FULL  = 16'hFFFF;
   localparam logic [3:0]  INVERT_HOLD = 4'd10;
   localparam logic [15:0] BEAT_CLAMP  = 16'd32768;
   localparam logic [21:0] BEAT_MUL    = 22'd5;
   localparam logic [21:0] COEF_MUL    = 22'd38;
   localparam logic [31:0] SCALE_RND   = 32'd4096;
   localparam int          SCALE_SHIFT = 13;
   localparam logic [15:0] POS_LIMIT   = 16'd32767;
   localparam logic [15:0] NEG_LIMIT   = 16'd32768;

   // register reset values
   localparam logic [15:0] GAIN_RESET   = 16'd4096;
   localparam logic [15:0] COEF_RESET   = 16'd6144;
   localparam logic        MANUAL_RESET = 1'b1;
   localparam logic        FORCE_RESET  = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_VOLUME_GAIN   = 2'd0,
      CSR_INVERT_COEF   = 2'd1,
      CSR_MANUAL_INVERT = 2'd2,
      CSR_FORCE_INVERT  = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic capture;
      logic scale;
      logic square;
      logic accum;
      logic div_load;
      logic div_step;
      logic root_load;
      logic root_step;
      logic smooth;
      logic blend;
      logic write;
   } alm_cmd_type;

   typedef struct packed {
      logic last;
   } alm_status_type;

endpackage

### rtl/alm_ctrl.sv
// ----------------------------------------------------------------------------
// alm_ctrl
// sequencer for the level meter: steps the datapath through scaling,
// accumulation, divide, square root and the per-buffer update
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alm_ctrl
   import alm_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           req_valid,
   output logic           req_ready,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   input  alm_status_type status,
   output alm_cmd_type    cmd
);

   typedef enum logic [10:0] {
      S_IDLE      = 11'b000_0000_0001,
      S_SCALE     = 11'b000_0000_0010,
      S_SQUARE    = 11'b000_0000_0100,
      S_ACCUM     = 11'b000_0000_1000,
      S_DIV_LOAD  = 11'b000_0001_0000,
      S_DIV       = 11'b000_0010_0000,
      S_ROOT_LOAD = 11'b000_0100_0000,
      S_ROOT      = 11'b000_1000_0000,
      S_SMOOTH    = 11'b001_0000_0000,
      S_BLEND     = 11'b010_0000_0000,
      S_WRITE     = 11'b100_0000_0000
   } state_type;

   state_type         state_ff, state_in;
   logic [STEP_W-1:0] step_ff, step_in;
   logic              rsp_valid_ff, rsp_valid_in;

   always_comb begin
      cmd          = '0;
      state_in     = state_ff;
      step_in      = step_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = S_SCALE;
            end
         end
         S_SCALE: begin
            cmd.scale = 1'b1;
            state_in  = S_SQUARE;
         end
         S_SQUARE: begin
            cmd.square = 1'b1;
            state_in   = S_ACCUM;
         end
         S_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = status.last ? S_DIV_LOAD : S_IDLE;
         end
         S_DIV_LOAD: begin
            cmd.div_load = 1'b1;
            step_in      = '0;
            state_in     = S_DIV;
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (step_ff == STEP_W'(NUM_W - 1)) begin
               state_in = S_ROOT_LOAD;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_ROOT_LOAD: begin
            cmd.root_load = 1'b1;
            step_in       = '0;
            state_in      = S_ROOT;
         end
         S_ROOT: begin
            cmd.root_step = 1'b1;
            if (step_ff == STEP_W'(ROOT_STEPS - 1)) begin
               state_in = S_SMOOTH;
            end else begin
               step_in = step_ff + 1'b1;
            end
         end
         S_SMOOTH: begin
            cmd.smooth = 1'b1;
            state_in   = S_BLEND;
         end
         S_BLEND: begin
            cmd.blend = 1'b1;
            state_in  = S_WRITE;
         end
         S_WRITE: begin
            // wait for the result slot to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.write    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         step_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         step_ff      <= step_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef SYNTH
   a_accept_starts_scale: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff == S_SCALE))
      else $error("accepted beat did not start scaling");

   a_write_needs_free_slot: assert property (@(posedge clock) disable iff (reset)
      cmd.write |-> (!rsp_valid_ff || rsp_ready))
      else $error("result written over a pending beat");

   a_write_raises_valid: assert property (@(posedge clock) disable iff (reset)
      cmd.write |=> rsp_valid_ff)
      else $error("result write not followed by valid");

   a_div_exits_to_root: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV && step_ff == STEP_W'(NUM_W - 1)) |=> (state_ff == S_ROOT_LOAD))
      else $error("divider did not hand over to square root");
`endif

endmodule

### rtl/alm_datapath.sv
// ----------------------------------------------------------------------------
// alm_datapath
// sample scaling and squaring, sum of squares, restoring divider, bit-pair
// square root, smoothing, peak hold, alpha and inversion hold
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module alm_datapath
   import alm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  alm_cmd_type           cmd,
   output alm_status_type        status,
   input  logic signed [15:0]    req_left_sample,
   input  logic signed [15:0]    req_right_sample,
   input  logic        [15:0]    req_beat_level,
   input  logic                  req_last_of_buffer,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]           csr_wdata,
   output logic [15:0]           rsp_smoothed_level,
   output logic [15:0]           rsp_peak_level,
   output logic [15:0]           rsp_fade_alpha,
   output logic                  rsp_invert_active,
   output logic [31:0]           rsp_buffer_index
);

   // configuration and per-buffer state
   logic [15:0]       gain_ff, gain_in;
   logic [15:0]       coef_ff, coef_in;
   logic              manual_ff, manual_in;
   logic              force_ff, force_in;
   logic [SUM_W-1:0]  sum_ff, sum_in;
   logic [CNT_W-1:0]  count_ff, count_in;
   logic [15:0]       smooth_ff, smooth_in;
   logic [15:0]       peak_ff, peak_in;
   logic              flag_ff, flag_in;
   logic [3:0]        timer_ff, timer_in;
   logic [31:0]       bufcnt_ff, bufcnt_in;

   // working registers
   logic [15:0]       left_ff, left_in;
   logic [15:0]       right_ff, right_in;
   logic              beat_hit_ff, beat_hit_in;
   logic              last_ff, last_in;
   logic [15:0]       scl_l_ff, scl_l_in;
   logic [15:0]       scl_r_ff, scl_r_in;
   logic [30:0]       sq_l_ff, sq_l_in;
   logic [30:0]       sq_r_ff, sq_r_in;
   logic [NUM_W-1:0]  num_ff, num_in;
   logic [CNT_W:0]    rem_ff, rem_in;
   logic [RAD_W-1:0]  rad_ff, rad_in;
   logic [RREM_W-1:0] rrem_ff, rrem_in;
   logic [ROOT_W-1:0] root_ff, root_in;
   logic [31:0]       prod_ff, prod_in;
   logic [15:0]       sm_new_ff, sm_new_in;
   logic [15:0]       alpha_ff, alpha_in;

   // combinational helpers
   logic [15:0]       beat_clamped;
   logic [CNT_W:0]    div_shift;
   logic              div_fit;
   logic [RREM_W-1:0] root_shift;
   logic [RREM_W-1:0] root_trial;
   logic              root_fit;
   logic [15:0]       level;
   logic [32:0]       blend_sum;
   logic [16:0]       blend_top;
   logic              inv_set;
   logic              inv_flag_mid;
   logic [3:0]        inv_timer_mid;
   logic [3:0]        inv_timer_inc;

   function automatic logic [15:0] scale_sample(input logic [15:0] smp,
                                                input logic [15:0] gain);
      logic        neg;
      logic [15:0] mag;
      logic [31:0] prod;
      logic [18:0] rounded;
      logic [15:0] limit;
      neg     = smp[15];
      mag     = neg ? (~smp + 16'd1) : smp;
      prod    = 32'(mag) * 32'(gain);
      rounded = 19'((prod + SCALE_RND) >> SCALE_SHIFT);
      limit   = neg ? NEG_LIMIT : POS_LIMIT;
      return (rounded > 19'(limit)) ? limit : rounded[15:0];
   endfunction

   always_comb begin
      beat_clamped = (req_beat_level > BEAT_CLAMP) ? BEAT_CLAMP : req_beat_level;

      div_shift = {rem_ff[CNT_W-1:0], num_ff[NUM_W-1]};
      div_fit   = (div_shift >= {1'b0, count_ff});

      root_shift = {rrem_ff[RREM_W-3:0], rad_ff[RAD_W-1:RAD_W-2]};
      root_trial = RREM_W'({root_ff, 2'b01});
      root_fit   = (root_shift >= root_trial);

      level     = root_ff[ROOT_W-1] ? LEVEL_FULL : root_ff[15:0];
      blend_sum = 33'(prod_ff) + 33'(32'(SMOOTH_NEW) * 32'(level));
      blend_top = blend_sum[32:16];

      inv_set       = (beat_hit_ff && !flag_ff && !manual_ff) || force_ff;
      inv_flag_mid  = inv_set || flag_ff;
      inv_timer_mid = inv_set ? 4'd0 : timer_ff;
      inv_timer_inc = inv_timer_mid + 4'd1;
   end

   always_comb begin
      gain_in     = gain_ff;
      coef_in     = coef_ff;
      manual_in   = manual_ff;
      force_in    = force_ff;
      sum_in      = sum_ff;
      count_in    = count_ff;
      smooth_in   = smooth_ff;
      peak_in     = peak_ff;
      flag_in     = flag_ff;
      timer_in    = timer_ff;
      bufcnt_in   = bufcnt_ff;
      left_in     = left_ff;
      right_in    = right_ff;
      beat_hit_in = beat_hit_ff;
      last_in     = last_ff;
      scl_l_in    = scl_l_ff;
      scl_r_in    = scl_r_ff;
      sq_l_in     = sq_l_ff;
      sq_r_in     = sq_r_ff;
      num_in      = num_ff;
      rem_in      = rem_ff;
      rad_in      = rad_ff;
      rrem_in     = rrem_ff;
      root_in     = root_ff;
      prod_in     = prod_ff;
      sm_new_in   = sm_new_ff;
      alpha_in    = alpha_ff;

      if (csr_write_en) begin
         case (csr_index_type'(csr_index))
            CSR_VOLUME_GAIN:   gain_in   = csr_wdata;
            CSR_INVERT_COEF:   coef_in   = csr_wdata;
            CSR_MANUAL_INVERT: manual_in = csr_wdata[0];
            CSR_FORCE_INVERT:  force_in  = csr_wdata[0];
            default: begin
            end
         endcase
      end

      if (cmd.capture) begin
         left_in     = $unsigned(req_left_sample);
         right_in    = $unsigned(req_right_sample);
         last_in     = req_last_of_buffer;
         beat_hit_in = (22'(beat_clamped) * BEAT_MUL) > (22'(coef_ff) * COEF_MUL);
      end

      if (cmd.scale) begin
         scl_l_in = scale_sample(left_ff, gain_ff);
         scl_r_in = scale_sample(right_ff, gain_ff);
      end

      if (cmd.square) begin
         sq_l_in = 31'(32'(scl_l_ff) * 32'(scl_l_ff));
         sq_r_in = 31'(32'(scl_r_ff) * 32'(scl_r_ff));
      end

      // pairs past the buffer limit are dropped
      if (cmd.accum && (count_ff < CNT_W'(MAX_PAIRS))) begin
         sum_in   = sum_ff + SUM_W'(sq_l_ff) + SUM_W'(sq_r_ff);
         count_in = count_ff + 1'b1;
      end

      // mean square: 2 * sum / count
      if (cmd.div_load) begin
         num_in = {sum_ff, 1'b0};
         rem_in = '0;
      end

      if (cmd.div_step) begin
         rem_in = div_fit ? (div_shift - {1'b0, count_ff}) : div_shift;
         num_in = {num_ff[NUM_W-2:0], div_fit};
      end

      if (cmd.root_load) begin
         rad_in  = (count_ff == '0) ? '0 : RAD_W'(num_ff[QUO_W-1:0]);
         rrem_in = '0;
         root_in = '0;
      end

      if (cmd.root_step) begin
         rrem_in = root_fit ? (root_shift - root_trial) : root_shift;
         root_in = {root_ff[ROOT_W-2:0], root_fit};
         rad_in  = {rad_ff[RAD_W-3:0], 2'b00};
      end

      if (cmd.smooth) begin
         prod_in = 32'(SMOOTH_OLD) * 32'(smooth_ff) + SMOOTH_RND;
      end

      if (cmd.blend) begin
         sm_new_in = blend_top[16] ? LEVEL_FULL : blend_top[15:0];
      end

      if (cmd.write) begin
         smooth_in = sm_new_ff;
         if (sm_new_ff > peak_ff) begin
            peak_in = sm_new_ff;
         end else begin
            peak_in = (peak_ff > PEAK_DECAY) ? (peak_ff - PEAK_DECAY) : 16'd0;
         end
         alpha_in = (sm_new_ff <= ALPHA_KNEE) ?
                    16'((19'(sm_new_ff) * 19'd5) >> 1) : LEVEL_FULL;
         if (inv_flag_mid) begin
            timer_in = inv_timer_inc;
            flag_in  = !(inv_timer_inc > INVERT_HOLD);
         end else begin
            timer_in = inv_timer_mid;
            flag_in  = 1'b0;
         end
         bufcnt_in = bufcnt_ff + 32'd1;
         sum_in    = '0;
         count_in  = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         gain_ff   <= GAIN_RESET;
         coef_ff   <= COEF_RESET;
         manual_ff <= MANUAL_RESET;
         force_ff  <= FORCE_RESET;
         sum_ff    <= '0;
         count_ff  <= '0;
         smooth_ff <= '0;
         peak_ff   <= '0;
         flag_ff   <= 1'b0;
         timer_ff  <= '0;
         bufcnt_ff <= '0;
      end else begin
         gain_ff   <= gain_in;
         coef_ff   <= coef_in;
         manual_ff <= manual_in;
         force_ff  <= force_in;
         sum_ff    <= sum_in;
         count_ff  <= count_in;
         smooth_ff <= smooth_in;
         peak_ff   <= peak_in;
         flag_ff   <= flag_in;
         timer_ff  <= timer_in;
         bufcnt_ff <= bufcnt_in;
      end
   end

   always_ff @(posedge clock) begin
      left_ff     <= left_in;
      right_ff    <= right_in;
      beat_hit_ff <= beat_hit_in;
      last_ff     <= last_in;
      scl_l_ff    <= scl_l_in;
      scl_r_ff    <= scl_r_in;
      sq_l_ff     <= sq_l_in;
      sq_r_ff     <= sq_r_in;
      num_ff      <= num_in;
      rem_ff      <= rem_in;
      rad_ff      <= rad_in;
      rrem_ff     <= rrem_in;
      root_ff     <= root_in;
      prod_ff     <= prod_in;
      sm_new_ff   <= sm_new_in;
      alpha_ff    <= alpha_in;
   end

   assign status.last        = last_ff;
   assign rsp_smoothed_level = smooth_ff;
   assign rsp_peak_level     = peak_ff;
   assign rsp_fade_alpha     = alpha_ff;
   assign rsp_invert_active  = flag_ff;
   assign rsp_buffer_index   = bufcnt_ff;

endmodule

### rtl/audio_level_meter_unit.sv
// ----------------------------------------------------------------------------
// audio_level_meter_unit
// stereo rms level meter with smoothing, decaying peak hold, fade alpha and
// beat-triggered inversion hold
// a pair that does not close a buffer passes scale, square and accumulate, then
// the next pair can be accepted; a closing pair goes on through the bit-serial
// divider, the square root and the smooth, blend and write update; a result
// waiting in the output slot stalls only the closing step
// synchronous active-high reset: registers to defaults, level state cleared
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module audio_level_meter_unit
   import alm_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic signed [15:0]    req_left_sample,
   input  logic signed [15:0]    req_right_sample,
   input  logic        [15:0]    req_beat_level,
   input  logic                  req_last_of_buffer,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [15:0]           rsp_smoothed_level,
   output logic [15:0]           rsp_peak_level,
   output logic [15:0]           rsp_fade_alpha,
   output logic                  rsp_invert_active,
   output logic [31:0]           rsp_buffer_index,
   input  logic                  csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [15:0]           csr_wdata
);

   alm_cmd_type    cmd;
   alm_status_type status;

   alm_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   alm_datapath u_datapath (
      .clock              (clock),
      .reset              (reset),
      .cmd                (cmd),
      .status             (status),
      .req_left_sample    (req_left_sample),
      .req_right_sample   (req_right_sample),
      .req_beat_level     (req_beat_level),
      .req_last_of_buffer (req_last_of_buffer),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata),
      .rsp_smoothed_level (rsp_smoothed_level),
      .rsp_peak_level     (rsp_peak_level),
      .rsp_fade_alpha     (rsp_fade_alpha),
      .rsp_invert_active  (rsp_invert_active),
      .rsp_buffer_index   (rsp_buffer_index)
   );

endmodule

### tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for audio_level_meter_unit: stereo beats are driven over
// valid/ready with random gaps while an in-bench level model predicts each
// buffer reading, and every reading is compared field by field in order
// covers register extremes, beat inversion, peak decay to zero and an
// over-long buffer, followed by randomized buffers under several settings
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
   import alm_pkg::*;

   localparam int PAIR_LIMIT    = MAX_PAIRS;
   localparam int TARGET_ITEMS  = 1650;
   localparam int CYCLE_LIMIT   = 500000;
   localparam int SETTLE_CYCLES = 80;
   localparam int IDLE_PCT      = 28;

   localparam logic [63:0] LVL_KEEP     = 64'd60948;
   localparam logic [63:0] LVL_TAKE     = 64'd4588;
   localparam logic [63:0] LVL_ROUND    = 64'd32768;
   localparam logic [15:0] PEAK_STEP    = 16'd66;
   localparam logic [15:0] FADE_KNEE    = 16'd3276;
   localparam logic [3:0]  HOLD_BUFFERS = 4'd10;
   localparam logic [15:0] BEAT_FULL    = 16'd32768;

   typedef enum int {
      SWING_FULL,
      SWING_SOFT,
      SWING_PEAK,
      SWING_MUTE
   } swing_mode_type;

   typedef struct packed {
      logic [15:0] left;
      logic [15:0] right;
      logic [15:0] beat;
      logic        last;
   } meter_pair_type;

   typedef struct packed {
      logic [15:0] smoothed;
      logic [15:0] peak;
      logic [15:0] alpha;
      logic        invert;
      logic [31:0] index;
   } meter_reading_type;

   typedef struct packed {
      meter_pair_type    pair;
      logic              typed;
      meter_reading_type reading;
   } directed_row_type;

   logic                 clock = 1'b0;
   logic                 reset = 1'b1;
   logic                 req_valid = 1'b0;
   logic                 req_ready;
   logic signed [15:0]   req_left_sample = '0;
   logic signed [15:0]   req_right_sample = '0;
   logic [15:0]          req_beat_level = '0;
   logic                 req_last_of_buffer = 1'b0;
   logic                 rsp_valid;
   logic                 rsp_ready = 1'b0;
   logic [15:0]          rsp_smoothed_level;
   logic [15:0]          rsp_peak_level;
   logic [15:0]          rsp_fade_alpha;
   logic                 rsp_invert_active;
   logic [31:0]          rsp_buffer_index;
   logic                 csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [15:0]          csr_wdata = '0;

   // register mirror and level state
   logic [15:0] gain_reg = 16'd4096;
   logic [15:0] coef_reg = 16'd6144;
   logic        manual_reg = 1'b1;
   logic        force_reg = 1'b1;
   logic [63:0] energy_sum = '0;
   int          pair_total = 0;
   logic [15:0] smooth_lvl = '0;
   logic [15:0] peak_lvl = '0;
   logic        invert_on = 1'b0;
   logic [3:0]  hold_timer = '0;
   logic [31:0] buffers_done = '0;

   meter_reading_type expected_readings[$];
   int          mismatches = 0;
   int          readings_checked = 0;
   int          items_sent = 0;
   int          cycle_count = 0;
   bit          no_idle = 1'b0;

   directed_row_type directed_rows [14] = '{
      '{'{16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b1,
        '{16'd0, 16'd0, 16'd0, 1'b1, 32'd1}},
      '{'{16'h7FFF, 16'h8000, 16'h8000, 1'b1}, 1'b0, '0},
      '{'{16'h8000, 16'h7FFF, 16'hFFFF, 1'b0}, 1'b0, '0},
      '{'{16'hFFFF, 16'h0001, 16'h8001, 1'b1}, 1'b0, '0},
      '{'{16'h5555, 16'hAAAA, 16'h0000, 1'b0}, 1'b0, '0},
      '{'{16'hAAAA, 16'h5555, 16'hFFFF, 1'b0}, 1'b0, '0},
      '{'{16'h0001, 16'hFFFF, 16'h7FFF, 1'b0}, 1'b0, '0},
      '{'{16'h7FFF, 16'h7FFF, 16'h8001, 1'b1}, 1'b0, '0},
      '{'{16'h0000, 16'h0000, 16'h0000, 1'b1}, 1'b0, '0},
      '{'{16'h8000, 16'h8000, 16'h0000, 1'b0}, 1'b0, '0},
      '{'{16'h8000, 16'h8000, 16'h0000, 1'b1}, 1'b0, '0},
      '{'{16'h0002, 16'hFFFE, 16'h0001, 1'b1}, 1'b0, '0},
      '{'{16'h00FF, 16'hFF00, 16'h00FF, 1'b0}, 1'b0, '0},
      '{'{16'hFF00, 16'h00FF, 16'hFF00, 1'b1}, 1'b0, '0}
   };

   audio_level_meter_unit uut (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_left_sample    (req_left_sample),
      .req_right_sample   (req_right_sample),
      .req_beat_level     (req_beat_level),
      .req_last_of_buffer (req_last_of_buffer),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_smoothed_level (rsp_smoothed_level),
      .rsp_peak_level     (rsp_peak_level),
      .rsp_fade_alpha     (rsp_fade_alpha),
      .rsp_invert_active  (rsp_invert_active),
      .rsp_buffer_index   (rsp_buffer_index),
      .csr_write_en       (csr_write_en),
      .csr_index          (csr_index),
      .csr_wdata          (csr_wdata)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles", cycle_count);
         $display("FAILURE");
         $finish;
      end
   end

   // squared sample after gain scaling (gain / 8192, rounded) and saturation
   function automatic logic [63:0] scaled_energy(input logic [15:0] s,
                                                 input logic [15:0] gain);
      logic [63:0] mag;
      logic [63:0] scaled;
      logic [63:0] lim;
      mag = s[15] ? (64'h10000 - {48'd0, s}) : {48'd0, s};
      scaled = (mag * {48'd0, gain} + 64'd4096) >> 13;
      lim = s[15] ? 64'd32768 : 64'd32767;
      if (scaled > lim) scaled = lim;
      return scaled * scaled;
   endfunction

   function automatic logic [63:0] floor_root(input logic [63:0] x);
      logic [63:0] root;
      logic [63:0] trial;
      root = '0;
      for (int b = 17; b >= 0; b--) begin
         trial = root | (64'd1 << b);
         if (trial * trial <= x) root = trial;
      end
      return root;
   endfunction

   // advances the level state by one beat, returns 1 when a buffer closes
   function automatic bit meter_advance(input meter_pair_type p,
                                        output meter_reading_type r);
      logic [63:0] beat;
      logic [63:0] mean;
      logic [63:0] lvl;
      logic [63:0] sm;
      bit          hit;
      r = '0;
      if (pair_total < PAIR_LIMIT) begin
         energy_sum += scaled_energy(p.left, gain_reg) + scaled_energy(p.right, gain_reg);
         pair_total++;
      end
      if (!p.last) return 1'b0;

      beat = (p.beat > BEAT_FULL) ? {48'd0, BEAT_FULL} : {48'd0, p.beat};
      hit = (64'd5 * beat) > (64'd38 * {48'd0, coef_reg});
      if ((hit && !invert_on && !manual_reg) || force_reg) begin
         invert_on = 1'b1;
         hold_timer = '0;
      end
      if (invert_on) begin
         hold_timer = hold_timer + 4'd1;
         if (hold_timer > HOLD_BUFFERS) invert_on = 1'b0;
      end

      mean = (pair_total != 0) ? (64'd2 * energy_sum) / 64'(pair_total) : 64'd0;
      lvl = floor_root(mean);
      if (lvl > 64'd65535) lvl = 64'd65535;
      sm = (LVL_KEEP * {48'd0, smooth_lvl} + LVL_TAKE * lvl + LVL_ROUND) >> 16;
      if (sm > 64'd65535) sm = 64'd65535;
      smooth_lvl = sm[15:0];

      if (smooth_lvl > peak_lvl) peak_lvl = smooth_lvl;
      else peak_lvl = (peak_lvl > PEAK_STEP) ? peak_lvl - PEAK_STEP : 16'd0;

      buffers_done = buffers_done + 32'd1;
      energy_sum = '0;
      pair_total = 0;

      r.smoothed = smooth_lvl;
      r.peak     = peak_lvl;
      r.alpha    = (smooth_lvl <= FADE_KNEE) ? 16'((32'(smooth_lvl) * 5) / 2) : 16'hFFFF;
      r.invert   = invert_on;
      r.index    = buffers_done;
      return 1'b1;
   endfunction

   task automatic report_mismatch(input string field, input logic [31:0] got,
                                  input logic [31:0] want);
      mismatches++;
      $display("mismatch %s at reading %0d: got %0d, want %0d",
               field, readings_checked, got, want);
   endtask

   always @(posedge clock) begin
      meter_reading_type want;
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (expected_readings.size() == 0) begin
               report_mismatch("unexpected reading, index", rsp_buffer_index, 32'd0);
            end else begin
               want = expected_readings.pop_front();
               if (rsp_smoothed_level !== want.smoothed)
                  report_mismatch("smoothed_level", rsp_smoothed_level, want.smoothed);
               if (rsp_peak_level !== want.peak)
                  report_mismatch("peak_level", rsp_peak_level, want.peak);
               if (rsp_fade_alpha !== want.alpha)
                  report_mismatch("fade_alpha", rsp_fade_alpha, want.alpha);
               if (rsp_invert_active !== want.invert)
                  report_mismatch("invert_active", rsp_invert_active, want.invert);
               if (rsp_buffer_index !== want.index)
                  report_mismatch("buffer_index", rsp_buffer_index, want.index);
            end
            readings_checked++;
         end
         rsp_ready <= no_idle || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   task automatic send_pair(input meter_pair_type p, input logic typed,
                            input meter_reading_type typed_reading);
      meter_reading_type r;
      while (!no_idle && $urandom_range(99) < IDLE_PCT) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid          <= 1'b1;
      req_left_sample    <= p.left;
      req_right_sample   <= p.right;
      req_beat_level     <= p.beat;
      req_last_of_buffer <= p.last;
      do @(posedge clock); while (!req_ready);
      items_sent++;
      if (meter_advance(p, r)) expected_readings.push_back(typed ? typed_reading : r);
   endtask

   function automatic logic [15:0] random_sample(input swing_mode_type mode);
      case (mode)
         SWING_SOFT: return 16'($urandom_range(600)) - 16'd300;
         SWING_PEAK: return ($urandom_range(1) != 0) ? 16'h8000 : 16'h7FFF;
         SWING_MUTE: return 16'd0;
         default:    return 16'($urandom);
      endcase
   endfunction

   task automatic send_buffer(input int len, input swing_mode_type mode);
      meter_pair_type p;
      for (int i = 0; i < len; i++) begin
         p.left  = random_sample(mode);
         p.right = random_sample(mode);
         p.beat  = ($urandom_range(1) != 0) ? 16'($urandom) : 16'($urandom_range(6000));
         p.last  = (i == len - 1);
         send_pair(p, 1'b0, '0);
      end
   endtask

   task automatic set_registers(input logic [15:0] gain, input logic [15:0] coef,
                                input logic manual, input logic force_on);
      csr_write_en <= 1'b1;
      csr_index    <= CSR_VOLUME_GAIN;
      csr_wdata    <= gain;
      @(posedge clock);
      csr_index    <= CSR_INVERT_COEF;
      csr_wdata    <= coef;
      @(posedge clock);
      csr_index    <= CSR_MANUAL_INVERT;
      csr_wdata    <= {15'd0, manual};
      @(posedge clock);
      csr_index    <= CSR_FORCE_INVERT;
      csr_wdata    <= {15'd0, force_on};
      @(posedge clock);
      csr_write_en <= 1'b0;
      gain_reg   = gain;
      coef_reg   = coef;
      manual_reg = manual;
      force_reg  = force_on;
   endtask

   task automatic settle();
      req_valid <= 1'b0;
      while (expected_readings.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic run_phase(input logic [15:0] gain, input logic [15:0] coef,
                            input logic manual, input logic force_on,
                            input int budget, input bit calm);
      int             sent;
      int             len;
      swing_mode_type mode;
      set_registers(gain, coef, manual, force_on);
      no_idle = calm;
      sent = 0;
      while (sent < budget) begin
         len = ($urandom_range(99) < 85) ? $urandom_range(6, 1) : $urandom_range(40, 7);
         case ($urandom_range(9))
            0, 1:    mode = SWING_SOFT;
            2:       mode = SWING_PEAK;
            3:       mode = SWING_MUTE;
            default: mode = SWING_FULL;
         endcase
         send_buffer(len, mode);
         sent += len;
      end
      settle();
      no_idle = 1'b0;
   endtask

   initial begin
      int floor_hits;
      int quiet_left;
      int tail;
      floor_hits = 0;
      quiet_left = 400;
      repeat (3) @(posedge clock);
      reset <= 1'b0;

      foreach (directed_rows[i])
         send_pair(directed_rows[i].pair, directed_rows[i].typed, directed_rows[i].reading);
      settle();

      // zero gain lets the peak decay all the way to the floor
      set_registers(16'd0, 16'd0, 1'b0, 1'b0);
      while (floor_hits < 4 && quiet_left > 0) begin
         send_buffer(1, SWING_FULL);
         if (peak_lvl == 16'd0) floor_hits++;
         quiet_left--;
      end
      settle();

      run_phase(16'hFFFF, 16'hFFFF, 1'b0, 1'b0, 120, 1'b0);
      run_phase(16'd8192, 16'($urandom_range(4400)), 1'b0, 1'b0, 150, 1'b1);

      // one buffer past the pair limit
      set_registers(16'($urandom), 16'($urandom_range(4400)), 1'b1, 1'b0);
      send_buffer(PAIR_LIMIT + 6, SWING_FULL);
      settle();

      run_phase(16'($urandom), 16'($urandom), 1'($urandom_range(1)), 1'b1, 100, 1'b0);
      tail = TARGET_ITEMS - items_sent;
      if (tail < 100) tail = 100;
      run_phase(16'($urandom_range(20000)), 16'($urandom_range(5000)), 1'b0, 1'b0,
                tail, 1'b0);

      $display("%0d beats sent, %0d buffer readings checked, %0d mismatches",
               items_sent, readings_checked, mismatches);
      $display("settings: reset values, zero and full gain, beat-driven and forced inversion");
      if (mismatches == 0) begin
         $display("SUCCESS");
      end else begin
         $display("FAILURE");
      end
      $finish;
   end

endmodule
